[rtl/mtfd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtfd_pkg
// Shared types and constants for the meter teleinfo frame decoder: control
// characters, result status codes and the fixed label table.
// ----------------------------------------------------------------------------
package mtfd_pkg;

    localparam int CHAR_BITS  = 7;
    localparam int TABLE_SIZE = 32;
    localparam int ENTRY_BITS = 56;
    localparam int NUM_BITS   = 40;
    localparam int TEXT_BITS  = 14;
    localparam int INDEX_BITS = 4;

    localparam logic [CHAR_BITS-1:0] CH_STX = 7'h02;
    localparam logic [CHAR_BITS-1:0] CH_ETX = 7'h03;
    localparam logic [CHAR_BITS-1:0] CH_LF  = 7'h0A;
    localparam logic [CHAR_BITS-1:0] CH_CR  = 7'h0D;
    localparam logic [CHAR_BITS-1:0] CH_SP  = 7'h20;

    localparam logic [NUM_BITS+3:0] NUM_SATURATE = 44'd999999999999;

    typedef enum logic [2:0] {
        ST_GROUP_OK  = 3'd0,
        ST_GROUP_BAD = 3'd1,
        ST_FRAME_OK  = 3'd2,
        ST_FRAME_BAD = 3'd3,
        ST_TIMEOUT   = 3'd4
    } t_status;

    // first character in the lowest seven bits
    localparam logic [ENTRY_BITS-1:0] LABEL_CHARS [TABLE_SIZE] = '{
        0:  {28'd0, 7'h4F, 7'h43, 7'h44, 7'h41},
        1:  {7'd0, 7'h46, 7'h49, 7'h52, 7'h41, 7'h54, 7'h50, 7'h4F},
        2:  {14'd0, 7'h43, 7'h53, 7'h55, 7'h4F, 7'h53, 7'h49},
        3:  {28'd0, 7'h50, 7'h48, 7'h43, 7'h48},
        4:  {28'd0, 7'h43, 7'h48, 7'h43, 7'h48},
        5:  {28'd0, 7'h43, 7'h45, 7'h54, 7'h50},
        6:  {21'd0, 7'h54, 7'h53, 7'h4E, 7'h49, 7'h49},
        7:  {28'd0, 7'h58, 7'h41, 7'h4D, 7'h49},
        8:  {28'd0, 7'h50, 7'h50, 7'h41, 7'h50},
        9:  {21'd0, 7'h43, 7'h48, 7'h50, 7'h48, 7'h48},
        10: {7'h54, 7'h41, 7'h54, 7'h45, 7'h44, 7'h54, 7'h4F, 7'h4D},
        default: '0
    };

    // zero length marks an unused slot
    localparam logic [3:0] LABEL_LEN [TABLE_SIZE] = '{
        0: 4'd4, 1: 4'd7, 2: 4'd6, 3: 4'd4, 4: 4'd4, 5: 4'd4,
        6: 4'd5, 7: 4'd4, 8: 4'd4, 9: 4'd5, 10: 4'd8,
        default: 4'd0
    };

endpackage

[rtl/meter_teleinfo_frame_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meter_teleinfo_frame_decoder
// Parses historic teleinfo frames character by character and reports group,
// frame end and timeout results with label index, value and first characters.
// Results are registered in an output entry, or in a skid entry while the
// output is held. Throughput: one character per cycle while the skid entry is
// empty; the per-character update of the parse state is a single register
// stage, with a two-entry result buffer. Reset: synchronous active-low; parser
// returns to hunting for a frame start and the result buffer empties.
// ----------------------------------------------------------------------------
module meter_teleinfo_frame_decoder
    import mtfd_pkg::*;
#(
    parameter int NUM_LABELS      = 11,
    parameter int MAX_LABEL_CHARS = 8,
    parameter int MAX_VALUE_CHARS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte[6:0], zero
    input  logic        s_tuser,   // is_timeout
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // label_index[3:0], value_number[43:4],
                                   // value_text[57:44], zero
    output logic [2:0]  m_tuser    // status
);

    localparam int LABEL_W = CHAR_BITS * MAX_LABEL_CHARS;
    localparam int LLEN_W  = $clog2(MAX_LABEL_CHARS + 1);
    localparam int VLEN_W  = $clog2(MAX_VALUE_CHARS + 1);
    localparam int SCAN    = (NUM_LABELS < TABLE_SIZE) ? NUM_LABELS : TABLE_SIZE;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_SKIP  = 3'd1,
        PH_LABEL = 3'd2,
        PH_VALUE = 3'd3,
        PH_CHECK = 3'd4
    } t_phase;

    typedef struct packed {
        t_status                status;
        logic [TEXT_BITS-1:0]   text;
        logic [NUM_BITS-1:0]    number;
        logic [INDEX_BITS-1:0]  index;
    } t_result;

    t_phase                 r_phase, n_phase;
    logic [CHAR_BITS-1:0]   r_prev, n_prev;
    logic [LABEL_W-1:0]     r_label, n_label;
    logic [LLEN_W-1:0]      r_label_len, n_label_len;
    logic [NUM_BITS-1:0]    r_acc, n_acc;
    logic                   r_digits, n_digits;
    logic [VLEN_W-1:0]      r_value_len, n_value_len;
    logic [TEXT_BITS-1:0]   r_first, n_first;
    logic [7:0]             r_sum, n_sum;
    logic                   r_failed, n_failed;

    t_result                r_out, r_skid, res;
    logic                   r_out_valid, r_skid_valid, res_valid;

    logic                   accept;
    logic [CHAR_BITS-1:0]   rx;
    logic                   found;
    logic [4:0]             found_idx;
    logic [NUM_BITS+3:0]    acc_next;

    assign s_tready = !r_skid_valid;
    assign accept   = s_tvalid && s_tready;
    assign rx       = s_tdata[CHAR_BITS-1:0];

    // exact label match against the table
    always_comb begin
        logic same;
        found     = 1'b0;
        found_idx = '0;
        for (int i = SCAN - 1; i >= 0; i--) begin
            same = (LABEL_LEN[i] != 4'd0) && (LABEL_LEN[i] == 4'(r_label_len));
            for (int k = 0; k < MAX_LABEL_CHARS; k++) begin
                if (k < int'(LABEL_LEN[i]) &&
                    r_label[CHAR_BITS*k +: CHAR_BITS] !=
                    LABEL_CHARS[i][CHAR_BITS*k +: CHAR_BITS]) begin
                    same = 1'b0;
                end
            end
            if (same) begin
                found     = 1'b1;
                found_idx = 5'(i);
            end
        end
    end

    assign acc_next = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1) + 44'(rx[3:0]);

    always_comb begin
        n_phase     = r_phase;
        n_prev      = r_prev;
        n_label     = r_label;
        n_label_len = r_label_len;
        n_acc       = r_acc;
        n_digits    = r_digits;
        n_value_len = r_value_len;
        n_first     = r_first;
        n_sum       = r_sum;
        n_failed    = r_failed;
        res         = '0;
        res_valid   = 1'b0;

        if (accept) begin
            if (s_tuser) begin
                n_phase    = PH_HUNT;
                n_prev     = '0;
                res.status = ST_TIMEOUT;
                res_valid  = 1'b1;
            end else begin
                n_prev = rx;
                if (r_phase == PH_HUNT) begin
                    if (r_prev == CH_ETX && rx == CH_STX) begin
                        n_phase  = PH_SKIP;
                        n_failed = 1'b0;
                    end
                end else if (rx == CH_ETX) begin
                    n_phase    = PH_HUNT;
                    res.status = r_failed ? ST_FRAME_BAD : ST_FRAME_OK;
                    res_valid  = 1'b1;
                end else if (rx == CH_LF || rx == CH_CR) begin
                    n_phase = PH_LABEL;
                end else begin
                    unique case (r_phase)
                        PH_SKIP: begin
                        end
                        PH_LABEL: begin
                            if (rx == CH_SP) begin
                                n_phase = (r_label_len == '0 || !found) ? PH_SKIP : PH_VALUE;
                            end else if (r_label_len >= LLEN_W'(MAX_LABEL_CHARS)) begin
                                n_phase = PH_SKIP;
                            end else begin
                                for (int k = 0; k < MAX_LABEL_CHARS; k++) begin
                                    if (r_label_len == LLEN_W'(k)) begin
                                        n_label[CHAR_BITS*k +: CHAR_BITS] = rx;
                                    end
                                end
                                n_label_len = r_label_len + LLEN_W'(1);
                                n_sum       = r_sum + {1'b0, rx};
                            end
                        end
                        PH_VALUE: begin
                            if (rx == CH_SP) begin
                                n_phase = PH_CHECK;
                            end else if (r_value_len >= VLEN_W'(MAX_VALUE_CHARS)) begin
                                n_phase = PH_SKIP;
                            end else begin
                                n_sum = r_sum + {1'b0, rx};
                                if (r_value_len == VLEN_W'(0)) begin
                                    n_first = {rx, 7'd0};
                                end else if (r_value_len == VLEN_W'(1)) begin
                                    n_first[CHAR_BITS-1:0] = rx;
                                end
                                n_value_len = r_value_len + VLEN_W'(1);
                                if (r_digits && rx >= 7'h30 && rx <= 7'h39) begin
                                    n_acc = (acc_next > NUM_SATURATE) ?
                                            NUM_SATURATE[NUM_BITS-1:0] :
                                            acc_next[NUM_BITS-1:0];
                                end else begin
                                    n_digits = 1'b0;
                                end
                            end
                        end
                        PH_CHECK: begin
                            n_phase = PH_SKIP;
                            if (!r_failed && found) begin
                                res_valid  = 1'b1;
                                res.index  = found_idx[INDEX_BITS-1:0];
                                res.number = r_acc;
                                res.text   = r_first;
                                if (({1'b0, r_sum[5:0]} + 7'd32) != rx) begin
                                    n_failed   = 1'b1;
                                    res.status = ST_GROUP_BAD;
                                end else begin
                                    res.status = ST_GROUP_OK;
                                end
                            end
                        end
                        default: begin
                            n_phase = PH_HUNT;
                        end
                    endcase
                end
            end

            // every exit to hunting, skip after stx, or new group clears the group
            if (s_tuser || n_phase == PH_HUNT ||
                (r_phase == PH_HUNT && n_phase == PH_SKIP) ||
                (r_phase != PH_HUNT && (rx == CH_LF || rx == CH_CR))) begin
                n_label     = '0;
                n_label_len = '0;
                n_acc       = '0;
                n_digits    = 1'b1;
                n_value_len = '0;
                n_first     = '0;
                n_sum       = 8'd32;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_prev       <= '0;
            r_label      <= '0;
            r_label_len  <= '0;
            r_acc        <= '0;
            r_digits     <= 1'b1;
            r_value_len  <= '0;
            r_first      <= '0;
            r_sum        <= 8'd32;
            r_failed     <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_prev      <= n_prev;
            r_label     <= n_label;
            r_label_len <= n_label_len;
            r_acc       <= n_acc;
            r_digits    <= n_digits;
            r_value_len <= n_value_len;
            r_first     <= n_first;
            r_sum       <= n_sum;
            r_failed    <= n_failed;
            if (!r_out_valid || m_tready) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out       <= res;
                    r_out_valid <= res_valid;
                end
            end else if (res_valid) begin
                r_skid       <= res;
                r_skid_valid <= 1'b1;
            end
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_out.status;
    assign m_tdata  = {6'd0, r_out.text, r_out.number, r_out.index};

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without output entry");

    a_timeout_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && s_tuser) |=> (r_phase == PH_HUNT && r_prev == '0))
        else $error("timeout did not return parser to hunting");

    a_end_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser != ST_GROUP_OK && m_tuser != ST_GROUP_BAD) |-> m_tdata == '0)
        else $error("frame end or timeout result carries data");

    a_label_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_label_len <= LLEN_W'(MAX_LABEL_CHARS))
        else $error("label length beyond limit");

    a_bad_sets_failed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && res.status == ST_GROUP_BAD) |=> r_failed)
        else $error("bad checksum did not mark frame failed");

endmodule

[bench/frame_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_result_checker
// Watches both stream channels of the teleinfo frame decoder. Every character
// transfer on the slave side is run through a local model of the frame
// parser. Every result it causes is queued. Each result transfer on the
// master side is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module frame_result_checker
    import mtfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte[6:0], zero
    input  logic        s_tuser,   // is_timeout
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,   // label_index[3:0], value_number[43:4],
                                   // value_text[57:44], zero
    input  logic [2:0]  m_tuser,   // status
    output int          o_fail_count,
    output int          o_pending
);

    localparam int          LABEL_LIMIT = 8;
    localparam int          VALUE_LIMIT = 12;
    localparam int          LABEL_COUNT = 11;
    localparam logic [43:0] VALUE_CAP   = 44'd999999999999;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_SKIP,
        PH_LABEL,
        PH_VALUE,
        PH_CHECK
    } t_phase;

    typedef struct packed {
        t_status     status;
        logic [3:0]  index;
        logic [39:0] number;
        logic [13:0] text;
    } t_result;

    t_phase      phase;
    logic [6:0]  prev_ch;
    logic [55:0] label_bits;
    logic [3:0]  label_cnt;
    logic [39:0] acc;
    logic        digits_only;
    logic [3:0]  value_cnt;
    logic [13:0] first_two;
    logic [7:0]  csum;
    logic        frame_bad;
    t_result     expected_results [$];
    int          fails = 0;

    function automatic string label_name(input int i);
        case (i)
            0:       return "ADCO";
            1:       return "OPTARIF";
            2:       return "ISOUSC";
            3:       return "HCHP";
            4:       return "HCHC";
            5:       return "PTEC";
            6:       return "IINST";
            7:       return "IMAX";
            8:       return "PAPP";
            9:       return "HHPHC";
            default: return "MOTDETAT";
        endcase
    endfunction

    function automatic int match_label();
        string name;
        byte   c;
        bit    same;
        for (int i = 0; i < LABEL_COUNT; i++) begin
            name = label_name(i);
            if (label_cnt != 0 && name.len() == int'(label_cnt)) begin
                same = 1'b1;
                for (int k = 0; k < name.len(); k++) begin
                    c = name[k];
                    if (label_bits[7*k +: 7] != c[6:0]) begin
                        same = 1'b0;
                    end
                end
                if (same) begin
                    return i;
                end
            end
        end
        return -1;
    endfunction

    task automatic clear_group();
        label_bits  = '0;
        label_cnt   = '0;
        acc         = '0;
        digits_only = 1'b1;
        value_cnt   = '0;
        first_two   = '0;
        csum        = 8'd32;
    endtask

    task automatic decode_char(input logic [6:0] ch, input logic tmo);
        logic [6:0]  last;
        logic [43:0] grown;
        int          idx;
        t_result     r;
        r = '0;
        if (tmo) begin
            phase   = PH_HUNT;
            prev_ch = '0;
            clear_group();
            r.status = ST_TIMEOUT;
            expected_results.push_back(r);
        end else begin
            last    = prev_ch;
            prev_ch = ch;
            if (phase == PH_HUNT) begin
                if (last == CH_ETX && ch == CH_STX) begin
                    phase     = PH_SKIP;
                    frame_bad = 1'b0;
                    clear_group();
                end
            end else if (ch == CH_ETX) begin
                r.status = frame_bad ? ST_FRAME_BAD : ST_FRAME_OK;
                expected_results.push_back(r);
                phase = PH_HUNT;
                clear_group();
            end else if (ch == CH_LF || ch == CH_CR) begin
                clear_group();
                phase = PH_LABEL;
            end else begin
                case (phase)
                    PH_LABEL: begin
                        if (ch == CH_SP) begin
                            phase = (match_label() < 0) ? PH_SKIP : PH_VALUE;
                        end else if (label_cnt >= LABEL_LIMIT) begin
                            phase = PH_SKIP;
                        end else begin
                            label_bits[7*label_cnt +: 7] = ch;
                            label_cnt = label_cnt + 4'd1;
                            csum      = csum + 8'(ch);
                        end
                    end
                    PH_VALUE: begin
                        if (ch == CH_SP) begin
                            phase = PH_CHECK;
                        end else if (value_cnt >= VALUE_LIMIT) begin
                            phase = PH_SKIP;
                        end else begin
                            csum = csum + 8'(ch);
                            if (value_cnt == 0) begin
                                first_two = {ch, 7'd0};
                            end else if (value_cnt == 1) begin
                                first_two[6:0] = ch;
                            end
                            value_cnt = value_cnt + 4'd1;
                            if (digits_only && ch >= 7'h30 && ch <= 7'h39) begin
                                grown = 44'(acc) * 44'd10 + 44'(ch - 7'h30);
                                acc   = (grown > VALUE_CAP) ? VALUE_CAP[39:0] : grown[39:0];
                            end else begin
                                digits_only = 1'b0;
                            end
                        end
                    end
                    PH_CHECK: begin
                        phase = PH_SKIP;
                        idx   = match_label();
                        if (!frame_bad && idx >= 0) begin
                            if (7'(csum[5:0]) + 7'd32 != ch) begin
                                frame_bad = 1'b1;
                                r.status  = ST_GROUP_BAD;
                            end else begin
                                r.status = ST_GROUP_OK;
                            end
                            r.index  = idx[3:0];
                            r.number = acc;
                            r.text   = first_two;
                            expected_results.push_back(r);
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    endtask

    task automatic flag(input string field, input logic [63:0] want, input logic [63:0] got);
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        fails++;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            phase     = PH_HUNT;
            prev_ch   = '0;
            frame_bad = 1'b0;
            clear_group();
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t ns: result with none expected, status %0d, data %h",
                             $time, m_tuser, m_tdata);
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_tuser != want.status) begin
                        flag("status", 64'(want.status), 64'(m_tuser));
                    end
                    if (m_tdata[3:0] != want.index) begin
                        flag("label_index", 64'(want.index), 64'(m_tdata[3:0]));
                    end
                    if (m_tdata[43:4] != want.number) begin
                        flag("value_number", 64'(want.number), 64'(m_tdata[43:4]));
                    end
                    if (m_tdata[57:44] != want.text) begin
                        flag("value_text", 64'(want.text), 64'(m_tdata[57:44]));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                decode_char(s_tdata[6:0], s_tuser);
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_results.size();
    end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the teleinfo frame decoder: a short directed frame, then
// random frames built mostly from well-formed groups with random values,
// mixed with broken groups, noise and timeouts. Both stream sides idle at
// random. The checker beside the block does all comparison.
// ----------------------------------------------------------------------------
module tb;
    import mtfd_pkg::*;

    localparam int ITEM_TARGET = 1050;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // rx_byte[6:0], zero
    logic        s_tuser;   // is_timeout
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // label_index[3:0], value_number[43:4],
                            // value_text[57:44], zero
    logic [2:0]  m_tuser;   // status

    int          fail_count;
    int          pending;
    int          sent;
    int          cycles;
    logic        steady;
    logic [6:0]  lab_q [$];
    logic [6:0]  val_q [$];

    meter_teleinfo_frame_decoder u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    frame_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    function automatic int idle_len();
        int roll;
        if (steady) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(1, 3);
        end else if (roll < 96) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [6:0] digit();
        return 7'h30 + 7'($urandom_range(0, 9));
    endfunction

    function automatic logic [6:0] printable();
        return 7'($urandom_range(33, 126));
    endfunction

    function automatic logic [6:0] group_check();
        logic [7:0] sum;
        sum = 8'd32;
        foreach (lab_q[k]) sum = sum + 8'(lab_q[k]);
        foreach (val_q[k]) sum = sum + 8'(val_q[k]);
        return 7'(sum[5:0]) + 7'd32;
    endfunction

    // receiver side
    initial begin
        int gap;
        m_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
            gap = idle_len();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    task automatic put_item(input logic [6:0] ch, input logic tmo);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, ch};
        s_tuser  <= tmo;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sent++;
    endtask

    task automatic load_label(input int i);
        lab_q.delete();
        for (int k = 0; k < int'(LABEL_LEN[i]); k++) begin
            lab_q.push_back(LABEL_CHARS[i][7*k +: 7]);
        end
    endtask

    task automatic make_value();
        int   len;
        int   roll;
        logic plain;
        val_q.delete();
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
            len = 0;
        end else if (roll < 25) begin
            len = 1;
        end else if (roll < 80) begin
            len = $urandom_range(2, 8);
        end else begin
            len = $urandom_range(9, 12);
        end
        plain = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 19) == 0) begin
            repeat (12) val_q.push_back(7'h39);
        end else begin
            repeat (len) begin
                val_q.push_back((plain || $urandom_range(0, 4) != 0) ? digit() : printable());
            end
        end
    endtask

    task automatic send_group(input logic [6:0] sep, input logic good);
        logic [6:0] ck;
        ck = group_check();
        if (!good) begin
            ck = ck ^ 7'($urandom_range(1, 63));
        end
        put_item(sep, 1'b0);
        foreach (lab_q[k]) put_item(lab_q[k], 1'b0);
        put_item(CH_SP, 1'b0);
        foreach (val_q[k]) put_item(val_q[k], 1'b0);
        put_item(CH_SP, 1'b0);
        put_item(ck, 1'b0);
    endtask

    task automatic random_group();
        int         kind;
        int         n;
        logic [6:0] sep;
        logic       good;
        kind = $urandom_range(0, 99);
        sep  = $urandom_range(0, 1) ? CH_LF : CH_CR;
        good = ($urandom_range(0, 99) < 88);
        load_label($urandom_range(0, 10));
        make_value();
        if (kind < 68) begin
            send_group(sep, good);
        end else if (kind < 74) begin
            // one letter changed, usually an unknown label
            lab_q[$urandom_range(0, lab_q.size() - 1)] = 7'($urandom_range(65, 90));
            send_group(sep, good);
        end else if (kind < 77) begin
            void'(lab_q.pop_back());
            send_group(sep, good);
        end else if (kind < 81) begin
            n = $urandom_range(9, 10);
            while (lab_q.size() < n) lab_q.push_back(7'($urandom_range(65, 90)));
            send_group(sep, good);
        end else if (kind < 84) begin
            lab_q.delete();
            send_group(sep, good);
        end else if (kind < 88) begin
            val_q.delete();
            repeat ($urandom_range(13, 15)) val_q.push_back(digit());
            send_group(sep, good);
        end else if (kind < 93) begin
            send_group(sep, good);
            repeat ($urandom_range(1, 4)) put_item(printable(), 1'b0);
        end else if (kind < 96) begin
            val_q.insert($urandom_range(0, val_q.size()), CH_STX);
            send_group(sep, good);
        end else if (kind < 98) begin
            // group cut short by the next separator
            put_item(sep, 1'b0);
            n = $urandom_range(0, lab_q.size());
            for (int k = 0; k < n; k++) put_item(lab_q[k], 1'b0);
        end else begin
            repeat ($urandom_range(1, 5)) put_item(7'($urandom_range(0, 127)), 1'b0);
        end
    endtask

    task automatic random_frame();
        int roll;
        steady = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) put_item(7'($urandom_range(0, 127)), 1'b0);
        end
        put_item(CH_ETX, 1'b0);
        put_item(CH_STX, 1'b0);
        repeat ($urandom_range(0, 2)) put_item(printable(), 1'b0);
        repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 49) == 0) begin
                put_item(7'($urandom_range(0, 127)), 1'b1);
            end
            random_group();
        end
        roll = $urandom_range(0, 99);
        if (roll < 85) begin
            put_item(CH_ETX, 1'b0);
        end else if (roll < 93) begin
            put_item(7'($urandom_range(0, 127)), 1'b1);
        end
    endtask

    initial begin
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        i_rst_n  <= 1'b0;
        steady   = 1'b0;
        sent     = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // timeout, frame start with junk, good group, bad group with empty value
        put_item(7'h7F, 1'b1);
        put_item(7'h00, 1'b0);
        put_item(CH_ETX, 1'b0);
        put_item(CH_STX, 1'b0);
        put_item(7'h58, 1'b0);
        load_label(0);
        val_q = {7'h31, 7'h32, 7'h33};
        send_group(CH_LF, 1'b1);
        load_label(10);
        val_q.delete();
        send_group(CH_CR, 1'b0);
        put_item(CH_ETX, 1'b0);

        while (sent < ITEM_TARGET) random_frame();

        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
